>>> hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by stepper_trapezoid_ramp.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

>>> hw/rtl/stramp_pkg.sv
// -----------------------------------------------------------------------------
// stramp_pkg
// Shared codes, widths and control structs of the stepper ramp generator.
// -----------------------------------------------------------------------------
package stramp_pkg;

  localparam int MODE_W    = 3;
  localparam int PHASE_W   = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 32;
  localparam int IN_DATA_W = 40;  // value + forward, padded to bytes
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DIR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOFT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HARD = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd5;

  // ramp phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_STEADY = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STOP   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = 3'd4;

  // register reset values, truncated to the period width where used
  localparam int unsigned START_RESET  = 64000;
  localparam int unsigned TARGET_RESET = 16000;
  localparam int unsigned ACCEL_RESET  = 100;
  localparam int unsigned DECEL_RESET  = 100;
  localparam int unsigned CEIL_RESET   = 64000;

  typedef struct packed {
    logic start;     // latch command, load divider
    logic div_step;  // one restoring-division step
    logic apply;     // commit next state and load result register
  } stramp_cmd_t;

  typedef struct packed {
    logic out_stall; // result register holds a transaction not yet taken
  } stramp_status_t;

endpackage

>>> hw/rtl/stepper_trapezoid_ramp.sv
// -----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal step-period ramp generator with command stream in, state out.
//
//   channel   dir  handshake              payload
//   s_axis    in   s_axis_tvalid/tready   tuser mode, tdata value + forward
//   m_axis    out  m_axis_tvalid/tready   tuser status, tdata ramp state
//   cfg       in   cfg_we_i               cfg_index_i, cfg_data_i
//
// An accepted command is latched, the bit-serial stop-distance divider then
// forms the quotient one bit per cycle, and commit loads the result register;
// the next command is taken only after the previous one has been committed.
// A new command is accepted while the previous result waits in the output
// register; commit stalls only if that result is still not taken.
// Reset is asynchronous, active low; no clearing pass is needed.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_trapezoid_ramp #(
  parameter int STEP_COUNT_BITS = 32,
  parameter int PERIOD_BITS     = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] value, [32] forward, rest zero
  input  logic [stramp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [2:0] mode
  input  logic [stramp_pkg::MODE_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // period, pulse_enable, phase, position, steps_left, zero fill
  output logic [((PERIOD_BITS + 1 + stramp_pkg::PHASE_W + stramp_pkg::POS_W
                  + STEP_COUNT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // [0] status
  output logic                                  m_axis_tuser,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [stramp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [PERIOD_BITS-1:0]                cfg_data_i
);

  localparam int OUT_BITS   = PERIOD_BITS + 1 + stramp_pkg::PHASE_W + stramp_pkg::POS_W
                              + STEP_COUNT_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  stramp_pkg::stramp_cmd_t    cmd;
  stramp_pkg::stramp_status_t status;

  logic [PERIOD_BITS-1:0]             out_period;
  logic                               out_enable;
  logic [stramp_pkg::PHASE_W-1:0]     out_phase;
  logic [stramp_pkg::POS_W-1:0]       out_position;
  logic [STEP_COUNT_BITS-1:0]         out_steps;

  stramp_ctrl #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stramp_datapath #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS),
    .PERIOD_BITS     (PERIOD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (s_axis_tuser),
    .value_i        (s_axis_tdata[stramp_pkg::VALUE_W-1:0]),
    .forward_i      (s_axis_tdata[stramp_pkg::VALUE_W]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_period_o   (out_period),
    .out_enable_o   (out_enable),
    .out_phase_o    (out_phase),
    .out_position_o (out_position),
    .out_steps_o    (out_steps),
    .out_status_o   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_steps, out_position, out_phase, out_enable,
                                     out_period});

  // a command in flight blocks the input for the next cycle
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
               "input accepted twice in a row")
  // commit never overwrites a result still waiting
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                cmd.apply && m_axis_tvalid && !m_axis_tready,
                "result overwritten")
  // a result appears only after a commit
  `ASSERT_PROP(a_valid_from_apply, clk_i, rst_ni,
               $rose(m_axis_tvalid) |-> $past(cmd.apply),
               "result without commit")

endmodule

>>> hw/rtl/stramp_div.sv
// -----------------------------------------------------------------------------
// stramp_div
// Bit-serial restoring divider, one quotient bit per step.
// -----------------------------------------------------------------------------
module stramp_div #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         init_i,
  input  logic         step_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quotient_o
);

  logic [W:0]   rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;

  assign rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (init_i) begin
      rem_d = '0;
      quo_d = dividend_i;
    end else if (step_i) begin
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_d = rem_sub;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/stramp_ctrl.sv
// -----------------------------------------------------------------------------
// stramp_ctrl
// Sequencer: accept a command, run the stop-distance division, commit.
// -----------------------------------------------------------------------------
module stramp_ctrl #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  stramp_pkg::stramp_status_t status_i,
  output stramp_pkg::stramp_cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(PERIOD_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(PERIOD_BITS - 1)) begin
          state_d = ST_APPLY;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_APPLY: begin
        // hold until the result register can take the new transaction
        if (!status_i.out_stall) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/stramp_datapath.sv
// -----------------------------------------------------------------------------
// stramp_datapath
// Configuration, ramp state, stop-distance divider and result register.
// -----------------------------------------------------------------------------
module stramp_datapath #(
  parameter int STEP_COUNT_BITS = 32,
  parameter int PERIOD_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  stramp_pkg::stramp_cmd_t                cmd_i,
  output stramp_pkg::stramp_status_t             status_o,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [stramp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [PERIOD_BITS-1:0]                 cfg_data_i,
  // command fields
  input  logic [stramp_pkg::MODE_W-1:0]          mode_i,
  input  logic [stramp_pkg::VALUE_W-1:0]         value_i,
  input  logic                                   forward_i,
  // result register
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [PERIOD_BITS-1:0]                 out_period_o,
  output logic                                   out_enable_o,
  output logic [stramp_pkg::PHASE_W-1:0]         out_phase_o,
  output logic [stramp_pkg::POS_W-1:0]           out_position_o,
  output logic [STEP_COUNT_BITS-1:0]             out_steps_o,
  output logic                                   out_status_o
);

  localparam int P = PERIOD_BITS;
  localparam int S = STEP_COUNT_BITS;

  // configuration registers
  logic [P-1:0] start_q, target_q, accel_q, decel_q, ceil_q;

  // ramp state
  logic [P-1:0]                      cur_q, cur_d;
  logic [S-1:0]                      rem_q, rem_d;
  logic [stramp_pkg::PHASE_W-1:0]    phase_q, phase_d;
  logic                              dir_q, dir_d;
  logic [stramp_pkg::POS_W-1:0]      pos_q, pos_d;
  logic                              gen_q, gen_d;
  logic                              status_d;

  // latched command
  logic [stramp_pkg::MODE_W-1:0]     mode_q;
  logic [stramp_pkg::VALUE_W-1:0]    value_q;
  logic                              fwd_q;

  logic                              out_valid_q;

  // tick helpers
  logic [P-1:0]                      span;
  logic [P-1:0]                      quotient;
  logic [S-1:0]                      stop_dist;
  logic                              rem_le1;
  logic [S-1:0]                      tick_rem;
  logic [stramp_pkg::PHASE_W-1:0]    tick_phase;
  logic [P-1:0]                      acc_period;
  logic [P:0]                        dec_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= P'(stramp_pkg::START_RESET);
      target_q <= P'(stramp_pkg::TARGET_RESET);
      accel_q  <= P'(stramp_pkg::ACCEL_RESET);
      decel_q  <= P'(stramp_pkg::DECEL_RESET);
      ceil_q   <= P'(stramp_pkg::CEIL_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        stramp_pkg::CFG_START:  start_q  <= cfg_data_i;
        stramp_pkg::CFG_TARGET: target_q <= cfg_data_i;
        stramp_pkg::CFG_ACCEL:  accel_q  <= cfg_data_i;
        stramp_pkg::CFG_DECEL:  decel_q  <= cfg_data_i;
        stramp_pkg::CFG_CEIL:   ceil_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturating span, divided while the command waits
  assign span = (ceil_q > cur_q) ? (ceil_q - cur_q) : '0;

  stramp_div #(
    .W (P)
  ) u_div (
    .clk_i      (clk_i),
    .init_i     (cmd_i.start),
    .step_i     (cmd_i.div_step),
    .dividend_i (span),
    .divisor_i  (decel_q),
    .quotient_o (quotient)
  );

  assign stop_dist = (decel_q == '0) ? '1 : S'(quotient);

  assign rem_le1    = (rem_q <= S'(1));
  assign tick_rem   = rem_le1 ? '0 : (rem_q - S'(1));
  assign tick_phase = rem_le1 ? stramp_pkg::PH_STOP : phase_q;
  assign acc_period = (accel_q >= cur_q) ? '0 : (cur_q - accel_q);
  assign dec_sum    = {1'b0, cur_q} + {1'b0, decel_q};

  always_comb begin
    cur_d    = cur_q;
    rem_d    = rem_q;
    phase_d  = phase_q;
    dir_d    = dir_q;
    pos_d    = pos_q;
    gen_d    = gen_q;
    status_d = 1'b0;
    unique case (mode_q)
      stramp_pkg::MODE_TICK: begin
        if (gen_q) begin
          rem_d   = tick_rem;
          phase_d = tick_phase;
          pos_d   = dir_q ? (pos_q + 32'd1) : (pos_q - 32'd1);
          case (tick_phase)
            stramp_pkg::PH_ACCEL: begin
              gen_d = 1'b1;
              if (target_q >= acc_period) begin
                cur_d   = target_q;
                phase_d = stramp_pkg::PH_STEADY;
              end else begin
                cur_d = acc_period;
              end
            end
            stramp_pkg::PH_STEADY: begin
              if (tick_rem <= stop_dist) begin
                phase_d = stramp_pkg::PH_DECEL;
              end
            end
            stramp_pkg::PH_DECEL: begin
              gen_d = 1'b1;
              if ({1'b0, ceil_q} <= dec_sum) begin
                cur_d   = ceil_q;
                phase_d = stramp_pkg::PH_STOP;
              end else begin
                cur_d = dec_sum[P-1:0];
              end
            end
            stramp_pkg::PH_STOP: begin
              gen_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      stramp_pkg::MODE_MOVE: begin
        rem_d   = value_q[S-1:0];
        cur_d   = start_q;
        phase_d = stramp_pkg::PH_ACCEL;
        gen_d   = 1'b1;
      end
      stramp_pkg::MODE_DIR: begin
        dir_d = fwd_q;
      end
      stramp_pkg::MODE_SOFT: begin
        rem_d = stop_dist;
      end
      stramp_pkg::MODE_HARD: begin
        gen_d = 1'b0;
      end
      stramp_pkg::MODE_LOAD: begin
        if (value_q != '0) begin
          pos_d = value_q;
        end else begin
          status_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= P'(stramp_pkg::CEIL_RESET);
      rem_q       <= '0;
      phase_q     <= stramp_pkg::PH_IDLE;
      dir_q       <= 1'b1;
      pos_q       <= '0;
      gen_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        cur_q   <= cur_d;
        rem_q   <= rem_d;
        phase_q <= phase_d;
        dir_q   <= dir_d;
        pos_q   <= pos_d;
        gen_q   <= gen_d;
      end
      if (cmd_i.apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q  <= mode_i;
      value_q <= value_i;
      fwd_q   <= forward_i;
    end
    if (cmd_i.apply) begin
      out_period_o   <= cur_d;
      out_enable_o   <= gen_d;
      out_phase_o    <= phase_d;
      out_position_o <= pos_d;
      out_steps_o    <= rem_d;
      out_status_o   <= status_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.out_stall = out_valid_q & ~out_ready_i;

endmodule
